// File: design/ssmc_pkg.sv
`default_nettype none

package ssmc_pkg;

    // default sizing
    localparam int SET_DEPTH_DEF   = 4096;
    localparam int OFFSET_BITS_DEF = 32;

    // fixed field widths
    localparam int OPCODE_W   = 2;
    localparam int OFFSET_W   = 32;
    localparam int SCORE_W    = 32;
    localparam int CNT_W      = 13;
    localparam int EITHER_W   = 14;
    localparam int LIMIT_W    = 13;
    localparam int WEIGHT_W   = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // saturation points of the hit counters
    localparam logic [CNT_W-1:0]    CNT_MAX    = '1;
    localparam logic [EITHER_W-1:0] EITHER_MAX = '1;

    // odds test: outside 45..55 percent means n*9 >= d*11 or d*9 >= n*11
    localparam int PROD_W   = 28;
    localparam int CMP_W    = 32;
    localparam int RATIO_LO = 9;
    localparam int RATIO_HI = 11;

    typedef enum logic [OPCODE_W-1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_KEY    = 2'd2,
        OP_CLEAR  = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIMIT_A   = 3'd0,
        CFG_LIMIT_B   = 3'd1,
        CFG_MIN_SCORE = 3'd2,
        CFG_MAX_SCORE = 3'd3,
        CFG_WEIGHT_A  = 3'd4,
        CFG_WEIGHT_B  = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_FIGURE,
        ST_DECIDE
    } state_t;

    // counts and settings handed to the verdict unit
    typedef struct packed {
        logic [CNT_W-1:0]    count_a;
        logic [CNT_W-1:0]    count_b;
        logic [EITHER_W-1:0] count_either;
        logic [LIMIT_W-1:0]  limit_a;
        logic [LIMIT_W-1:0]  limit_b;
        logic [WEIGHT_W-1:0] weight_a;
        logic [WEIGHT_W-1:0] weight_b;
    } verdict_in_t;

    // one result item
    typedef struct packed {
        logic [CNT_W-1:0]    hits_a;
        logic [CNT_W-1:0]    hits_b;
        logic [EITHER_W-1:0] hits_either;
        logic                reportable;
        logic                favors_a;
    } result_t;

endpackage

`default_nettype wire

// File: design/sorted_set_match_counter.sv
`default_nettype none

// channel   signals                                  handshake
// ------    ---------------------------------------  ------------------------------
// item in   opcode, offset, score, last              start & !busy
// result    hits_a, hits_b, hits_either, reportable, done, one cycle, no backpressure
//           favors_a
// config    cfg_index, cfg_data                      cfg_valid & cfg_ready
//
// load, clear and skipped key items are taken while idle; a probed key item
// steps both cursors until the longer of the two set walks is done, since
// each set memory returns one entry a cycle. a last item then runs the verdict,
// and the result pulses on done in the same cycle that busy drops.
// reset empties both sets, clears counts and cursors and loads the register
// defaults; set memories are not cleared, entries beyond the fill count are
// never used. results cannot be stalled.
module sorted_set_match_counter #(
    parameter int SET_DEPTH   = ssmc_pkg::SET_DEPTH_DEF,
    parameter int OFFSET_BITS = ssmc_pkg::OFFSET_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [ssmc_pkg::OPCODE_W-1:0]       opcode,
    input  wire logic [ssmc_pkg::OFFSET_W-1:0]       offset,
    input  wire logic signed [ssmc_pkg::SCORE_W-1:0] score,
    input  wire logic                                last,
    output logic                                     done,
    output logic [ssmc_pkg::CNT_W-1:0]               hits_a,
    output logic [ssmc_pkg::CNT_W-1:0]               hits_b,
    output logic [ssmc_pkg::EITHER_W-1:0]            hits_either,
    output logic                                     reportable,
    output logic                                     favors_a,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ssmc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [ssmc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = $clog2(SET_DEPTH);
    localparam int CW = $clog2(SET_DEPTH + 1);
    localparam int OW = (OFFSET_BITS < ssmc_pkg::OFFSET_W) ? OFFSET_BITS : ssmc_pkg::OFFSET_W;

    ssmc_pkg::state_t state_reg;
    ssmc_pkg::state_t state_next;

    logic                                probe_active;
    logic                                verdict_go;
    logic                                list_clear;

    logic [ssmc_pkg::LIMIT_W-1:0]        limit_a_reg;
    logic [ssmc_pkg::LIMIT_W-1:0]        limit_b_reg;
    logic signed [ssmc_pkg::SCORE_W-1:0] min_score_reg;
    logic signed [ssmc_pkg::SCORE_W-1:0] max_score_reg;
    logic [ssmc_pkg::WEIGHT_W-1:0]       weight_a_reg;
    logic [ssmc_pkg::WEIGHT_W-1:0]       weight_b_reg;

    logic [CW-1:0]                       size_a_reg;
    logic [CW-1:0]                       size_b_reg;
    logic [CW-1:0]                       cursor_a_reg;
    logic [CW-1:0]                       cursor_b_reg;
    logic [CW-1:0]                       cursor_a_next;
    logic [CW-1:0]                       cursor_b_next;
    logic [ssmc_pkg::CNT_W-1:0]          count_a_reg;
    logic [ssmc_pkg::CNT_W-1:0]          count_b_reg;
    logic [ssmc_pkg::EITHER_W-1:0]       count_either_reg;
    logic [OW-1:0]                       prev_offset_reg;
    logic                                prev_valid_reg;
    logic [OW-1:0]                       key_offset_reg;
    logic                                key_last_reg;

    logic                                accept;
    logic [OW-1:0]                       off_in;
    logic                                load_a;
    logic                                load_b;
    logic                                clear_sets;
    logic                                key_in;
    logic                                is_dup;
    logic                                in_range;
    logic                                go_probe;
    logic                                skip_last;

    logic [OW-1:0]                       rdata_a;
    logic [OW-1:0]                       rdata_b;
    logic                                a_more;
    logic                                b_more;
    logic                                hit_a;
    logic                                hit_b;
    logic                                probe_done;

    ssmc_pkg::verdict_in_t               vin;
    ssmc_pkg::result_t                   res;

    // input decode
    assign accept     = start && !busy;
    assign off_in     = offset[OW-1:0];
    assign load_a     = accept && (opcode == ssmc_pkg::OP_LOAD_A);
    assign load_b     = accept && (opcode == ssmc_pkg::OP_LOAD_B);
    assign clear_sets = accept && (opcode == ssmc_pkg::OP_CLEAR);
    assign key_in     = accept && (opcode == ssmc_pkg::OP_KEY);
    assign is_dup     = prev_valid_reg && (off_in == prev_offset_reg);
    assign in_range   = (score >= min_score_reg) && (score <= max_score_reg);
    assign go_probe   = key_in && !is_dup && in_range;
    assign skip_last  = key_in && !go_probe && last;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_a_reg   <= ssmc_pkg::LIMIT_W'(1);
            limit_b_reg   <= ssmc_pkg::LIMIT_W'(1);
            min_score_reg <= {1'b1, {(ssmc_pkg::SCORE_W-1){1'b0}}};
            max_score_reg <= {1'b0, {(ssmc_pkg::SCORE_W-1){1'b1}}};
            weight_a_reg  <= ssmc_pkg::WEIGHT_W'(1);
            weight_b_reg  <= ssmc_pkg::WEIGHT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ssmc_pkg::CFG_LIMIT_A:   limit_a_reg   <= cfg_data[ssmc_pkg::LIMIT_W-1:0];
                ssmc_pkg::CFG_LIMIT_B:   limit_b_reg   <= cfg_data[ssmc_pkg::LIMIT_W-1:0];
                ssmc_pkg::CFG_MIN_SCORE: min_score_reg <= $signed(cfg_data);
                ssmc_pkg::CFG_MAX_SCORE: max_score_reg <= $signed(cfg_data);
                ssmc_pkg::CFG_WEIGHT_A:  weight_a_reg  <= cfg_data[ssmc_pkg::WEIGHT_W-1:0];
                ssmc_pkg::CFG_WEIGHT_B:  weight_b_reg  <= cfg_data[ssmc_pkg::WEIGHT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // set memories, read address follows the cursor
    ssmc_ram #(
        .WIDTH (OW),
        .DEPTH (SET_DEPTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (load_a && (size_a_reg != CW'(SET_DEPTH))),
        .waddr (size_a_reg[AW-1:0]),
        .wdata (off_in),
        .raddr (cursor_a_next[AW-1:0]),
        .rdata (rdata_a)
    );

    ssmc_ram #(
        .WIDTH (OW),
        .DEPTH (SET_DEPTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (load_b && (size_b_reg != CW'(SET_DEPTH))),
        .waddr (size_b_reg[AW-1:0]),
        .wdata (off_in),
        .raddr (cursor_b_next[AW-1:0]),
        .rdata (rdata_b)
    );

    // cursor walk compare
    assign a_more     = (cursor_a_reg < size_a_reg) && (rdata_a < key_offset_reg);
    assign b_more     = (cursor_b_reg < size_b_reg) && (rdata_b < key_offset_reg);
    assign hit_a      = (cursor_a_reg < size_a_reg) && (rdata_a == key_offset_reg);
    assign hit_b      = (cursor_b_reg < size_b_reg) && (rdata_b == key_offset_reg);
    assign probe_done = probe_active && !a_more && !b_more;

    // cursor next values
    always_comb
    begin
        cursor_a_next = cursor_a_reg;
        cursor_b_next = cursor_b_reg;
        if (clear_sets || list_clear)
        begin
            cursor_a_next = '0;
            cursor_b_next = '0;
        end
        else if (probe_active)
        begin
            if (a_more)
            begin
                cursor_a_next = cursor_a_reg + CW'(1);
            end
            if (b_more)
            begin
                cursor_b_next = cursor_b_reg + CW'(1);
            end
        end
    end

    // state machine: next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ssmc_pkg::ST_IDLE:
            begin
                if (go_probe)
                begin
                    state_next = ssmc_pkg::ST_PROBE;
                end
                else if (skip_last)
                begin
                    state_next = ssmc_pkg::ST_FIGURE;
                end
            end
            ssmc_pkg::ST_PROBE:
            begin
                if (!a_more && !b_more)
                begin
                    state_next = key_last_reg ? ssmc_pkg::ST_FIGURE : ssmc_pkg::ST_IDLE;
                end
            end
            ssmc_pkg::ST_FIGURE:
            begin
                state_next = ssmc_pkg::ST_DECIDE;
            end
            ssmc_pkg::ST_DECIDE:
            begin
                state_next = ssmc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ssmc_pkg::ST_IDLE;
            end
        endcase
    end

    // state machine: outputs
    always_comb
    begin
        busy         = 1'b1;
        probe_active = 1'b0;
        verdict_go   = 1'b0;
        list_clear   = 1'b0;
        unique case (state_reg)
            ssmc_pkg::ST_IDLE:   busy         = 1'b0;
            ssmc_pkg::ST_PROBE:  probe_active = 1'b1;
            ssmc_pkg::ST_FIGURE: verdict_go   = 1'b1;
            ssmc_pkg::ST_DECIDE: list_clear   = 1'b1;
            default:             busy         = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssmc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // set fill counts and cursors
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_a_reg   <= '0;
            size_b_reg   <= '0;
            cursor_a_reg <= '0;
            cursor_b_reg <= '0;
        end
        else
        begin
            cursor_a_reg <= cursor_a_next;
            cursor_b_reg <= cursor_b_next;
            if (clear_sets)
            begin
                size_a_reg <= '0;
                size_b_reg <= '0;
            end
            else
            begin
                if (load_a && (size_a_reg != CW'(SET_DEPTH)))
                begin
                    size_a_reg <= size_a_reg + CW'(1);
                end
                if (load_b && (size_b_reg != CW'(SET_DEPTH)))
                begin
                    size_b_reg <= size_b_reg + CW'(1);
                end
            end
        end
    end

    // hit counters and duplicate tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a_reg      <= '0;
            count_b_reg      <= '0;
            count_either_reg <= '0;
            prev_offset_reg  <= '0;
            prev_valid_reg   <= 1'b0;
        end
        else if (clear_sets || list_clear)
        begin
            count_a_reg      <= '0;
            count_b_reg      <= '0;
            count_either_reg <= '0;
            prev_offset_reg  <= '0;
            prev_valid_reg   <= 1'b0;
        end
        else if (probe_done)
        begin
            if (hit_a && (count_a_reg != ssmc_pkg::CNT_MAX))
            begin
                count_a_reg <= count_a_reg + ssmc_pkg::CNT_W'(1);
            end
            if (hit_b && (count_b_reg != ssmc_pkg::CNT_MAX))
            begin
                count_b_reg <= count_b_reg + ssmc_pkg::CNT_W'(1);
            end
            if ((hit_a || hit_b) && (count_either_reg != ssmc_pkg::EITHER_MAX))
            begin
                count_either_reg <= count_either_reg + ssmc_pkg::EITHER_W'(1);
            end
            prev_offset_reg <= key_offset_reg;
            prev_valid_reg  <= 1'b1;
        end
        else if (key_in && !is_dup)
        begin
            prev_valid_reg <= 1'b0;
        end
    end

    // key item capture
    always_ff @(posedge clk)
    begin
        if (key_in)
        begin
            key_offset_reg <= off_in;
            key_last_reg   <= last;
        end
    end

    // odds verdict
    assign vin.count_a      = count_a_reg;
    assign vin.count_b      = count_b_reg;
    assign vin.count_either = count_either_reg;
    assign vin.limit_a      = limit_a_reg;
    assign vin.limit_b      = limit_b_reg;
    assign vin.weight_a     = weight_a_reg;
    assign vin.weight_b     = weight_b_reg;

    ssmc_verdict u_verdict (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (verdict_go),
        .vin   (vin),
        .res   (res),
        .done  (done)
    );

    assign hits_a      = res.hits_a;
    assign hits_b      = res.hits_b;
    assign hits_either = res.hits_either;
    assign reportable  = res.reportable;
    assign favors_a    = res.favors_a;

`ifndef SYNTHESIS
    // a result follows a verdict start through the stage 1 and stage 2 registers
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ssmc_pkg::ST_FIGURE, 2))
        else $error("result without verdict start");

    // either count covers each single-set count
    assert property (@(posedge clk) disable iff (!rst_n)
        (ssmc_pkg::EITHER_W'(count_a_reg) <= count_either_reg)
        && (ssmc_pkg::EITHER_W'(count_b_reg) <= count_either_reg))
        else $error("either count below a set count");

    // cursors never pass the fill count
    assert property (@(posedge clk) disable iff (!rst_n)
        (cursor_a_reg <= size_a_reg) && (cursor_b_reg <= size_b_reg))
        else $error("cursor beyond set size");

    // a probe ends in a walk that finished on both sets
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssmc_pkg::ST_PROBE) && (state_next != ssmc_pkg::ST_PROBE)
        |=> $stable(cursor_a_reg) && $stable(cursor_b_reg))
        else $error("cursor moved after probe end");
`endif

endmodule

`default_nettype wire

// File: design/ssmc_ram.sv
`default_nettype none

module ssmc_ram #(
    parameter int WIDTH = ssmc_pkg::OFFSET_BITS_DEF,
    parameter int DEPTH = ssmc_pkg::SET_DEPTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: design/ssmc_verdict.sv
`default_nettype none

module ssmc_verdict (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   go,
    input  wire ssmc_pkg::verdict_in_t  vin,
    output ssmc_pkg::result_t           res,
    output logic                        done
);

    logic [ssmc_pkg::WEIGHT_W-1:0] wa;
    logic [ssmc_pkg::WEIGHT_W-1:0] wb;
    logic [ssmc_pkg::EITHER_W-1:0] bonly;
    logic [ssmc_pkg::EITHER_W-1:0] a_plus;
    logic [ssmc_pkg::EITHER_W:0]   b_plus;
    logic [ssmc_pkg::PROD_W-1:0]   n_next;
    logic [ssmc_pkg::PROD_W-1:0]   d_next;

    logic [ssmc_pkg::PROD_W-1:0]   n_reg;
    logic [ssmc_pkg::PROD_W-1:0]   d_reg;
    logic                          limit_met_reg;
    logic [ssmc_pkg::CNT_W-1:0]    hits_a_reg;
    logic [ssmc_pkg::CNT_W-1:0]    hits_b_reg;
    logic [ssmc_pkg::EITHER_W-1:0] hits_either_reg;
    logic                          s1_valid_reg;

    logic [ssmc_pkg::CMP_W-1:0]    n9;
    logic [ssmc_pkg::CMP_W-1:0]    n11;
    logic [ssmc_pkg::CMP_W-1:0]    d9;
    logic [ssmc_pkg::CMP_W-1:0]    d11;

    ssmc_pkg::result_t             res_reg;
    logic                          done_reg;

    // stage 1: prior-weighted odds numerator and denominator
    always_comb
    begin
        wa     = (vin.weight_a == '0) ? ssmc_pkg::WEIGHT_W'(1) : vin.weight_a;
        wb     = (vin.weight_b == '0) ? ssmc_pkg::WEIGHT_W'(1) : vin.weight_b;
        bonly  = (vin.count_either >= ssmc_pkg::EITHER_W'(vin.count_a))
                 ? vin.count_either - ssmc_pkg::EITHER_W'(vin.count_a) : '0;
        a_plus = ssmc_pkg::EITHER_W'(vin.count_a) + ssmc_pkg::EITHER_W'(1);
        b_plus = {1'b0, bonly} + (ssmc_pkg::EITHER_W+1)'(1);
        n_next = ssmc_pkg::PROD_W'(a_plus) * ssmc_pkg::PROD_W'(wb);
        d_next = ssmc_pkg::PROD_W'(b_plus) * ssmc_pkg::PROD_W'(wa);
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            n_reg           <= n_next;
            d_reg           <= d_next;
            limit_met_reg   <= (vin.count_a >= vin.limit_a) || (vin.count_b >= vin.limit_b);
            hits_a_reg      <= vin.count_a;
            hits_b_reg      <= vin.count_b;
            hits_either_reg <= vin.count_either;
        end
    end

    // stage 2: odds band test and sign
    always_comb
    begin
        n9  = ssmc_pkg::CMP_W'(n_reg) * ssmc_pkg::CMP_W'(ssmc_pkg::RATIO_LO);
        n11 = ssmc_pkg::CMP_W'(n_reg) * ssmc_pkg::CMP_W'(ssmc_pkg::RATIO_HI);
        d9  = ssmc_pkg::CMP_W'(d_reg) * ssmc_pkg::CMP_W'(ssmc_pkg::RATIO_LO);
        d11 = ssmc_pkg::CMP_W'(d_reg) * ssmc_pkg::CMP_W'(ssmc_pkg::RATIO_HI);
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            res_reg.hits_a      <= hits_a_reg;
            res_reg.hits_b      <= hits_b_reg;
            res_reg.hits_either <= hits_either_reg;
            res_reg.reportable  <= limit_met_reg && ((n9 >= d11) || (d9 >= n11));
            res_reg.favors_a    <= n_reg > d_reg;
        end
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= go;
            done_reg     <= s1_valid_reg;
        end
    end

    assign res  = res_reg;
    assign done = done_reg;

endmodule

`default_nettype wire
